// ===== rtl/gray_encoder_delta_tracker_defines.svh =====
// Assertion macros shared by the encoder delta tracker RTL.
`ifndef GRAY_ENCODER_DELTA_TRACKER_DEFINES_SVH
`define GRAY_ENCODER_DELTA_TRACKER_DEFINES_SVH

// Check cons in the cycle after ante; expects clk and rst in scope.
`define GEDT_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Check cons in the same cycle as ante; expects clk and rst in scope.
`define GEDT_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gedt_pkg.sv =====
// Package: constants, request codes and Gray decode for the encoder delta tracker.
`timescale 1ns / 1ps

package gedt_pkg;

  localparam int MAX_BITS_DEFAULT = 16;

  localparam int WORD_W  = 16;
  localparam int TIME_W  = 32;
  localparam int ACC_W   = 32;
  localparam int RES_W   = 5;

  localparam logic [RES_W-1:0] RES_RESET = 5'd12;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_TICK   = 1'b1
  } req_t;

  // Each binary bit is the XOR of the Gray bits at and above it.
  function automatic logic [WORD_W-1:0] gray_to_bin(input logic [WORD_W-1:0] g);
    logic [WORD_W-1:0] b;
    for (int i = 0; i < WORD_W; i++) begin
      b[i] = ^(g >> i);
    end
    return b;
  endfunction

endpackage

// ===== rtl/gray_encoder_delta_tracker.sv =====
// Top level: Gray absolute encoder position decoder with delta accumulation.
`timescale 1ns / 1ps
// An accepted input item has its result item in the output register in the cycle after it is taken.
// Throughput: 1 item per cycle; the state update (decode, subtract, fold, 32-bit add)
//   sits in one combinational stage. A result held by m_axis_tready low blocks the input;
//   a new item enters in the same cycle the waiting result drains.
// Reset (rst, synchronous, active high): position, accumulator, delta, total, tick time
//   and interval clear to zero, resolution returns to 12 bits, output goes invalid.

`include "gray_encoder_delta_tracker_defines.svh"

module gray_encoder_delta_tracker #(
  parameter int MAX_BITS = gedt_pkg::MAX_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,

  // configuration: resolution_bits
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [4:0]   cfg_data,

  // input items
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,   // [15:0] gray_word, [47:16] now_us
  input  logic         s_axis_tuser,   // [0] req_type

  // result items
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // [15:0] position, [31:16] step_delta,
                                       // [63:32] tick_delta, [95:64] total_counts,
                                       // [127:96] interval_us
);

  // step arithmetic: DW bits hold a masked difference, SW bits hold the folded step
  localparam int DW = MAX_BITS;
  localparam int SW = MAX_BITS + 1;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic [gedt_pkg::RES_W-1:0]  resolution_bits;
  logic [gedt_pkg::WORD_W-1:0] last_position;
  logic                        primed;
  logic [gedt_pkg::ACC_W-1:0]  pending_delta;
  logic [gedt_pkg::ACC_W-1:0]  latched_delta;
  logic [gedt_pkg::ACC_W-1:0]  count_total;
  logic [gedt_pkg::TIME_W-1:0] last_tick_time;
  logic [gedt_pkg::TIME_W-1:0] last_interval;

  logic [127:0] out_data;
  logic         out_valid;

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  logic in_accept;

  assign cfg_ready     = 1'b1;
  // take a new item whenever the output register is empty or drains this cycle
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Input unpack
  // ---------------------------------------------------------------------------
  gedt_pkg::req_t              req_type;
  logic [gedt_pkg::WORD_W-1:0] gray_word;
  logic [gedt_pkg::TIME_W-1:0] now_us;

  assign req_type  = gedt_pkg::req_t'(s_axis_tuser);
  assign gray_word = s_axis_tdata[15:0];
  assign now_us    = s_axis_tdata[47:16];

  // ---------------------------------------------------------------------------
  // Effective resolution: zero acts as one, values above MAX_BITS clamp
  // ---------------------------------------------------------------------------
  logic [gedt_pkg::RES_W-1:0] eff_bits;

  always_comb begin
    if (resolution_bits == '0) begin
      eff_bits = gedt_pkg::RES_W'(1);
    end else if ({1'b0, resolution_bits} > 6'(MAX_BITS)) begin
      eff_bits = gedt_pkg::RES_W'(MAX_BITS);
    end else begin
      eff_bits = resolution_bits;
    end
  end

  // counts per revolution, its half and the wrap mask
  logic [SW-1:0] cpr;
  logic [SW-1:0] cpr_half;
  logic [DW-1:0] mask_d;
  logic [31:0]   mask_32;

  assign cpr      = SW'(1) << eff_bits;
  assign cpr_half = cpr >> 1;
  assign mask_d   = DW'(cpr - SW'(1));
  assign mask_32  = 32'(mask_d);

  // ---------------------------------------------------------------------------
  // Sample path: decode, wrapped difference, fold into the signed range
  // ---------------------------------------------------------------------------
  logic [gedt_pkg::WORD_W-1:0] pos;
  logic [31:0]                 diff_full;
  logic [DW-1:0]               diff;
  logic signed [SW-1:0]        step_s;
  logic [31:0]                 step_32;

  assign pos       = gedt_pkg::gray_to_bin(gray_word & mask_32[15:0]);
  assign diff_full = 32'(pos) - 32'(last_position);
  assign diff      = diff_full[DW-1:0] & mask_d;

  always_comb begin
    // upper half of the circle reads as a backward step
    if ((diff & cpr_half[DW-1:0]) != '0) begin
      step_s = signed'({1'b0, diff} - cpr);
    end else begin
      step_s = signed'({1'b0, diff});
    end
  end

  // first sample after reset only sets the position
  assign step_32 = primed ? 32'(step_s) : 32'd0;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  logic [gedt_pkg::WORD_W-1:0] last_position_next;
  logic                        primed_next;
  logic [gedt_pkg::ACC_W-1:0]  pending_delta_next;
  logic [gedt_pkg::ACC_W-1:0]  latched_delta_next;
  logic [gedt_pkg::ACC_W-1:0]  count_total_next;
  logic [gedt_pkg::TIME_W-1:0] last_tick_time_next;
  logic [gedt_pkg::TIME_W-1:0] last_interval_next;
  logic [15:0]                 step_field;

  always_comb begin
    last_position_next  = last_position;
    primed_next         = primed;
    pending_delta_next  = pending_delta;
    latched_delta_next  = latched_delta;
    count_total_next    = count_total;
    last_tick_time_next = last_tick_time;
    last_interval_next  = last_interval;
    step_field          = '0;
    case (req_type)
      gedt_pkg::REQ_SAMPLE: begin
        last_position_next = pos;
        primed_next        = 1'b1;
        pending_delta_next = pending_delta + step_32;
        step_field         = step_32[15:0];
      end
      gedt_pkg::REQ_TICK: begin
        // latch the accumulator, fold it into the total, restart accumulation
        last_interval_next  = now_us - last_tick_time;
        last_tick_time_next = now_us;
        latched_delta_next  = pending_delta;
        count_total_next    = count_total + pending_delta;
        pending_delta_next  = '0;
      end
      default: begin
        step_field = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      resolution_bits <= gedt_pkg::RES_RESET;
      last_position   <= '0;
      primed          <= 1'b0;
      pending_delta   <= '0;
      latched_delta   <= '0;
      count_total     <= '0;
      last_tick_time  <= '0;
      last_interval   <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        resolution_bits <= cfg_data;
      end
      if (in_accept) begin
        last_position  <= last_position_next;
        primed         <= primed_next;
        pending_delta  <= pending_delta_next;
        latched_delta  <= latched_delta_next;
        count_total    <= count_total_next;
        last_tick_time <= last_tick_time_next;
        last_interval  <= last_interval_next;
        out_valid      <= 1'b1;
      end else if (m_axis_tready) begin
        // drop the result once taken
        out_valid <= 1'b0;
      end
    end
  end

  // result payload: hold while stalled, load on accept
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= {last_interval_next, count_total_next, latched_delta_next,
                   step_field, last_position_next};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `GEDT_CHECK_NOW(a_unprimed_no_pending, !primed, pending_delta == '0,
    "accumulator nonzero before first sample")
  `GEDT_CHECK_NEXT(a_tick_clears, in_accept && s_axis_tuser == gedt_pkg::REQ_TICK,
    pending_delta == '0 && latched_delta == m_axis_tdata[63:32],
    "tick did not latch and clear the accumulator")
  `GEDT_CHECK_NEXT(a_tick_total, in_accept && s_axis_tuser == gedt_pkg::REQ_TICK,
    m_axis_tdata[95:64] == $past(count_total) + $past(pending_delta),
    "tick total mismatch")
  `GEDT_CHECK_NEXT(a_first_sample_zero,
    in_accept && s_axis_tuser == gedt_pkg::REQ_SAMPLE && !primed,
    m_axis_tdata[31:16] == '0 && primed && pending_delta == $past(pending_delta),
    "first sample produced a step")

endmodule
